@@ rtl/bts_pkg.sv @@
// Shared types and constants of the bilinear texture sampler.
package bts_pkg;

   // Fixed widths of the channel and configuration ports.
   localparam int POS_W      = 17;
   localparam int CHAN_W     = 16;
   localparam int OUT_W      = 16;
   localparam int CFG_SIZE_W = 9;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int KIND_W     = 2;

   // Input beat opcodes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Register indexes (byte address divided by four).
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WRAP_MODE    = 2'd2;

   // Kinds of command handed from the front end to the back end.
   typedef enum logic [KIND_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_BLACK  = 2'd2
   } cmd_kind_type;

   // Configuration as seen by the front end.
   typedef struct packed {
      logic [CFG_SIZE_W-1:0] image_width;
      logic [CFG_SIZE_W-1:0] image_height;
      logic                  wrap_mode;
   } cfg_type;

endpackage

@@ rtl/bts_req_if.sv @@
// Request channel: pixel writes and sample positions.
interface bts_req_if;
   import bts_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [CHAN_W-1:0]       red;
   logic [CHAN_W-1:0]       green;
   logic [CHAN_W-1:0]       blue;

   modport source (output valid, opcode, pos_x, pos_y, red, green, blue, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, red, green, blue, output ready);
endinterface

@@ rtl/bts_rsp_if.sv @@
// Response channel: interpolated colours.
interface bts_rsp_if;
   import bts_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] out_red;
   logic [OUT_W-1:0] out_green;
   logic [OUT_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

@@ rtl/bts_ram.sv @@
// Generic single-port RAM with registered read data.
module bts_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle; the read returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/bts_queue.sv @@
// Short first-in first-out queue between the front and back ends.
module bts_queue #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ rtl/bts_front.sv @@
// Front end: accepts request beats, classifies them and works out pixel addresses.
module bts_front #(
   parameter int MAX_SIDE     = 256,
   parameter int CHANNEL_BITS = 16,
   parameter int FRAC_BITS    = 8,
   localparam int ADDR_W      = $clog2(MAX_SIDE * MAX_SIDE),
   localparam int CMD_W       = bts_pkg::KIND_W + 4 * ADDR_W + 2 * FRAC_BITS
                                + 3 * CHANNEL_BITS
) (
   bts_req_if.sink          req,
   input  bts_pkg::cfg_type cfg,
   input  logic             clearing,
   output logic             push_valid,
   input  logic             push_ready,
   output logic [CMD_W-1:0] push_data
);
   import bts_pkg::*;

   localparam int COORD_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int INT_W   = POS_W - FRAC_BITS;
   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int SZ_W    = (SIDE_W > CFG_SIZE_W) ? SIDE_W : CFG_SIZE_W;
   localparam int CW      = ((INT_W > SZ_W) ? INT_W : SZ_W) + 1;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [ADDR_W-1:0]       a00;
      logic [ADDR_W-1:0]       a01;
      logic [ADDR_W-1:0]       a10;
      logic [ADDR_W-1:0]       a11;
      logic [FRAC_BITS-1:0]    fx;
      logic [FRAC_BITS-1:0]    fy;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } cmd_type;

   // A size register of zero acts as one, and one above the store's side as the side.
   function automatic logic [SZ_W-1:0] eff_side(input logic [CFG_SIZE_W-1:0] v);
      logic [SZ_W-1:0] e;
      e = SZ_W'(v);
      if (e == '0) begin
         e = SZ_W'(1);
      end else if (e > SZ_W'(MAX_SIDE)) begin
         e = SZ_W'(MAX_SIDE);
      end
      return e;
   endfunction

   // Pixels are stored row by row at a fixed pitch of the store's side.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);
   endfunction

   logic [SZ_W-1:0]    w_eff, h_eff;
   logic [CW-1:0]      xi, yi, xn, yn;
   logic [COORD_W-1:0] x0, x1, y0, y1;
   logic               outside;
   cmd_type            cmd;

   // Integer parts, range check and neighbour selection.
   always_comb begin
      w_eff   = eff_side(cfg.image_width);
      h_eff   = eff_side(cfg.image_height);
      xi      = CW'(req.pos_x[POS_W-1:FRAC_BITS]);
      yi      = CW'(req.pos_y[POS_W-1:FRAC_BITS]);
      outside = req.pos_x[POS_W-1] || req.pos_y[POS_W-1]
                || (xi >= CW'(w_eff)) || (yi >= CW'(h_eff));
      xn      = xi + CW'(1);
      yn      = yi + CW'(1);
      x0      = COORD_W'(xi);
      y0      = COORD_W'(yi);
      if (xn >= CW'(w_eff)) begin
         x1 = cfg.wrap_mode ? '0 : COORD_W'(w_eff - SZ_W'(1));
      end else begin
         x1 = COORD_W'(xn);
      end
      if (yn >= CW'(h_eff)) begin
         y1 = cfg.wrap_mode ? '0 : COORD_W'(h_eff - SZ_W'(1));
      end else begin
         y1 = COORD_W'(yn);
      end
   end

   // Command for the back end.
   always_comb begin
      if (req.opcode == OP_WRITE) begin
         cmd.kind = CMD_WRITE;
      end else if (outside) begin
         cmd.kind = CMD_BLACK;
      end else begin
         cmd.kind = CMD_SAMPLE;
      end
      cmd.a00   = cell_addr(y0, x0);
      cmd.a01   = cell_addr(y0, x1);
      cmd.a10   = cell_addr(y1, x0);
      cmd.a11   = cell_addr(y1, x1);
      cmd.fx    = req.pos_x[FRAC_BITS-1:0];
      cmd.fy    = req.pos_y[FRAC_BITS-1:0];
      cmd.red   = CHANNEL_BITS'(req.red);
      cmd.green = CHANNEL_BITS'(req.green);
      cmd.blue  = CHANNEL_BITS'(req.blue);
   end

   // A write outside the image is taken and dropped here.
   assign req.ready  = push_ready && !clearing;
   assign push_valid = req.valid && req.ready && !((req.opcode == OP_WRITE) && outside);
   assign push_data  = cmd;
endmodule

@@ rtl/bts_back.sv @@
// Back end: clears the pixel store, does writes, blends four neighbours or sends black.
module bts_back #(
   parameter int MAX_SIDE     = 256,
   parameter int CHANNEL_BITS = 16,
   parameter int FRAC_BITS    = 8,
   localparam int ADDR_W      = $clog2(MAX_SIDE * MAX_SIDE),
   localparam int CMD_W       = bts_pkg::KIND_W + 4 * ADDR_W + 2 * FRAC_BITS
                                + 3 * CHANNEL_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  logic [CMD_W-1:0] cmd_data,
   output logic             clearing,
   bts_rsp_if.source        rsp
);
   import bts_pkg::*;

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int PIX_W = 3 * CHANNEL_BITS;
   localparam int HW    = CHANNEL_BITS + FRAC_BITS;
   localparam int VW    = CHANNEL_BITS + 2 * FRAC_BITS;
   localparam int WT_W  = FRAC_BITS + 1;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [ADDR_W-1:0]       a00;
      logic [ADDR_W-1:0]       a01;
      logic [ADDR_W-1:0]       a10;
      logic [ADDR_W-1:0]       a11;
      logic [FRAC_BITS-1:0]    fx;
      logic [FRAC_BITS-1:0]    fy;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_A01  = 6'b000010,
      ST_A10  = 6'b000100,
      ST_A11  = 6'b001000,
      ST_LAST = 6'b010000,
      ST_OUT  = 6'b100000
   } back_state_type;

   cmd_type           head;
   cmd_type           cmd_ff, cmd_in;
   back_state_type    state_ff, state_in;
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  ram_wdata, ram_rdata;
   logic              slot_free, load_black, load_res;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WT_W-1:0]   wx0, wy0;

   logic [CHANNEL_BITS-1:0] pix      [3];
   logic [HW-1:0]           part_ff  [3];
   logic [HW-1:0]           part_in  [3];
   logic [HW-1:0]           top_ff   [3];
   logic [HW-1:0]           top_in   [3];
   logic [HW-1:0]           bot_ff   [3];
   logic [HW-1:0]           bot_in   [3];
   logic [VW-1:0]           vt_ff    [3];
   logic [VW-1:0]           vt_in    [3];
   logic [VW-1:0]           blend    [3];
   logic [OUT_W-1:0]        out_ff   [3];
   logic [OUT_W-1:0]        out_in   [3];

   assign head      = cmd_type'(cmd_data);
   assign clearing  = clear_ff;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   bts_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Sequencer: one store access per cycle, four reads per sample.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      cmd_ready   = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = cmd_ff.a00;
      ram_wdata   = {head.blue, head.green, head.red};
      load_black  = 1'b0;
      load_res    = 1'b0;
      if (clear_ff) begin
         ram_we      = 1'b1;
         ram_addr    = clr_addr_ff;
         ram_wdata   = '0;
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  case (head.kind)
                     CMD_WRITE: begin
                        ram_we    = 1'b1;
                        ram_addr  = head.a00;
                        cmd_ready = 1'b1;
                     end
                     CMD_BLACK: begin
                        if (slot_free) begin
                           load_black = 1'b1;
                           cmd_ready  = 1'b1;
                        end
                     end
                     CMD_SAMPLE: begin
                        ram_addr  = head.a00;
                        cmd_in    = head;
                        cmd_ready = 1'b1;
                        state_in  = ST_A01;
                     end
                     default: begin
                        cmd_ready = 1'b1;
                     end
                  endcase
               end
            end
            ST_A01: begin
               ram_addr = cmd_ff.a01;
               state_in = ST_A10;
            end
            ST_A10: begin
               ram_addr = cmd_ff.a10;
               state_in = ST_A11;
            end
            ST_A11: begin
               ram_addr = cmd_ff.a11;
               state_in = ST_LAST;
            end
            ST_LAST: begin
               state_in = ST_OUT;
            end
            ST_OUT: begin
               if (slot_free) begin
                  load_res = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // Blend lanes: horizontal pass on each row, then the vertical pass.
   always_comb begin
      wx0 = (WT_W'(1) << FRAC_BITS) - WT_W'(cmd_ff.fx);
      wy0 = (WT_W'(1) << FRAC_BITS) - WT_W'(cmd_ff.fy);
      for (int ch = 0; ch < 3; ch++) begin
         pix[ch]     = ram_rdata[ch*CHANNEL_BITS +: CHANNEL_BITS];
         part_in[ch] = part_ff[ch];
         top_in[ch]  = top_ff[ch];
         bot_in[ch]  = bot_ff[ch];
         vt_in[ch]   = vt_ff[ch];
         case (state_ff)
            ST_A01: begin
               part_in[ch] = HW'(pix[ch]) * HW'(wx0);
            end
            ST_A10: begin
               top_in[ch] = part_ff[ch] + HW'(pix[ch]) * HW'(cmd_ff.fx);
            end
            ST_A11: begin
               part_in[ch] = HW'(pix[ch]) * HW'(wx0);
               vt_in[ch]   = VW'(top_ff[ch]) * VW'(wy0);
            end
            ST_LAST: begin
               bot_in[ch] = part_ff[ch] + HW'(pix[ch]) * HW'(cmd_ff.fx);
            end
            default: begin
            end
         endcase
         blend[ch] = vt_ff[ch] + VW'(bot_ff[ch]) * VW'(cmd_ff.fy);
         if (load_black) begin
            out_in[ch] = '0;
         end else if (load_res) begin
            out_in[ch] = OUT_W'(blend[ch] >> (2 * FRAC_BITS));
         end else begin
            out_in[ch] = out_ff[ch];
         end
      end
   end

   // Output register holds a finished beat while the back end moves on.
   always_comb begin
      if (load_black || load_res) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      for (int ch = 0; ch < 3; ch++) begin
         part_ff[ch] <= part_in[ch];
         top_ff[ch]  <= top_in[ch];
         bot_ff[ch]  <= bot_in[ch];
         vt_ff[ch]   <= vt_in[ch];
         out_ff[ch]  <= out_in[ch];
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_red   = out_ff[0];
   assign rsp.out_green = out_ff[1];
   assign rsp.out_blue  = out_ff[2];

   // No pixel write may land while a sample's reads are under way.
   a_no_write_mid_sample: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !ram_we)
      else $error("pixel store written during a sample");

   // A finished sample waits while the output register is occupied.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !slot_free) |=> (state_ff == ST_OUT))
      else $error("sample result left before the output register was free");

   // Nothing is taken from the queue during the clearing pass.
   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !cmd_ready)
      else $error("command taken during the clearing pass");
endmodule

@@ rtl/bilinear_texture_sampler.sv @@
// Top level of the bilinear texture sampler: register port, front end, queue and back end.
//
//   Channel   Kind         Carries
//   req_if    beat in      opcode, pos_x, pos_y, red, green, blue
//   rsp_if    beat out     out_red, out_green, out_blue
//   p*        APB slave    image_width @0x0, image_height @0x4, wrap_mode @0x8
//
// A sample inside the image occupies the back end for four reads of the single-port pixel
// store, a state for the last read data and one for the final blend. A pixel write goes
// straight to the store; a sample outside the image is answered with black. After reset a
// clearing pass writes zero to all MAX_SIDE*MAX_SIDE pixels, during which req_if.ready is
// low; register writes are taken throughout.
// A two-entry queue lets the front end keep taking beats while the back end works, and
// the output register holds a result while rsp_if.ready is low.
module bilinear_texture_sampler #(
   parameter int MAX_SIDE     = 256,
   parameter int CHANNEL_BITS = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   bts_req_if.sink                        req_if,
   bts_rsp_if.source                      rsp_if,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bts_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bts_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bts_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import bts_pkg::*;

   localparam int ADDR_W    = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int CMD_W     = KIND_W + 4 * ADDR_W + 2 * FRAC_BITS + 3 * CHANNEL_BITS;
   localparam int QUEUE_LEN = 2;

   logic [CFG_SIZE_W-1:0] width_ff, width_in;
   logic [CFG_SIZE_W-1:0] height_ff, height_in;
   logic                  wrap_ff, wrap_in;
   logic [CSR_IDX_W-1:0]  reg_idx;
   logic                  csr_write;
   cfg_type               cfg;
   logic                  push_valid, push_ready, pop_valid, pop_ready, clearing;
   logic [CMD_W-1:0]      push_data, pop_data;

   // Register port: writes complete in the access phase, reads are combinational.
   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      wrap_in   = wrap_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:  width_in  = pwdata[CFG_SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[CFG_SIZE_W-1:0];
            REG_WRAP_MODE:    wrap_in   = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_WRAP_MODE:    prdata = CSR_DATA_W'(wrap_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_SIZE_W'(256);
         height_ff <= CFG_SIZE_W'(256);
         wrap_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         wrap_ff   <= wrap_in;
      end
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.wrap_mode    = wrap_ff;

   bts_front #(
      .MAX_SIDE     (MAX_SIDE),
      .CHANNEL_BITS (CHANNEL_BITS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_front (
      .req        (req_if),
      .cfg        (cfg),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bts_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_LEN)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bts_back #(
      .MAX_SIDE     (MAX_SIDE),
      .CHANNEL_BITS (CHANNEL_BITS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .clearing  (clearing),
      .rsp       (rsp_if)
   );
endmodule
